// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL file that carries checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define LLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check an implication whose consequent is checked in the cycle after the antecedent
`define LLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lls_pkg.sv -----
// Package: widths, keyword patterns, class codes and the result type
`default_nettype none

package lls_pkg;

  localparam int COUNT_WIDTH = 64;   // counter width, 16 to 64
  localparam int OUT_CW      = 64;   // width of the reported totals
  localparam int NUM_KIND    = 5;
  localparam int HIST_BYTES  = 4;

  localparam logic [2:0] KIND_ERROR = 3'd0;
  localparam logic [2:0] KIND_WARN  = 3'd1;
  localparam logic [2:0] KIND_INFO  = 3'd2;
  localparam logic [2:0] KIND_DEBUG = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;

  localparam logic [7:0] BYTE_NL   = 8'h0A;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  localparam logic [39:0] KW_ERROR = 40'h4552524F52;
  localparam logic [39:0] KW_FATAL = 40'h464154414C;
  localparam logic [23:0] KW_ERR   = 24'h457272;
  localparam logic [31:0] KW_WARN  = 32'h5741524E;
  localparam logic [31:0] KW_INFO  = 32'h494E464F;
  localparam logic [39:0] KW_DEBUG = 40'h4445425547;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [2:0]                         line_kind;
    logic [NUM_KIND-1:0][OUT_CW-1:0]    totals;
    logic                               final_result;
  } result_t;

  // Highest-priority class among the flags (bit0 error .. bit3 debug)
  function automatic logic [2:0] line_class(input logic [3:0] seen);
    logic [2:0] k;
    if (seen[0])      k = KIND_ERROR;
    else if (seen[1]) k = KIND_WARN;
    else if (seen[2]) k = KIND_INFO;
    else if (seen[3]) k = KIND_DEBUG;
    else              k = KIND_OTHER;
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lls_if.sv -----
// Stream interfaces for the byte input and the line result channels
`default_nettype none

interface lls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface lls_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  line_kind;
  logic [63:0] error_total;
  logic [63:0] warn_total;
  logic [63:0] info_total;
  logic [63:0] debug_total;
  logic [63:0] other_total;
  logic        final_result;

  modport source (output valid, output line_kind, output error_total, output warn_total,
                  output info_total, output debug_total, output other_total,
                  output final_result, input ready);
  modport sink   (input valid, input line_kind, input error_total, input warn_total,
                  input info_total, input debug_total, input other_total,
                  input final_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/lls_byte_cell.sv -----
// One byte of the line history shift chain
`default_nettype none

module lls_byte_cell
  import lls_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       shift_en,
  input  wire logic       clear,
  input  wire logic [7:0] d,
  output logic [7:0]      q
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (clear) begin
      byte_nxt = BYTE_ZERO;
    end else if (shift_en) begin
      byte_nxt = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= BYTE_ZERO;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign q = byte_r;

endmodule

`default_nettype wire

// ----- rtl/lls_count_cell.sv -----
// Saturating line counter for one class
`default_nettype none

module lls_count_cell
  import lls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic inc,
  output count_t    count_nxt
);

  count_t count_r;

  // hold at all ones
  assign count_nxt = (inc && (count_r != {COUNT_WIDTH{1'b1}}))
                     ? count_r + COUNT_WIDTH'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/log_line_severity_counter_unit.sv -----
// Top level: log line classifier with saturating per-class line counts
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------
//  in_ch    | in  | valid / ready    | data_byte[7:0], stream_end
//  out_ch   | out | valid / ready    | line_kind[2:0], five 64-bit totals,
//           |     |                  | final_result
//
//  One byte is taken every cycle while in_ch.ready is high; its keyword matches,
//  history shift and counter bump complete in the cycle of the transfer.
//  A line result is registered to out_ch, or to the spare slot if it stalls.
//  Results go into a two-slot output buffer; in_ch.ready drops only while both
//  slots hold results, so one stalled result does not block the input.
//  Synchronous active-low reset clears history, flags, counts and the buffer.
`default_nettype none

`include "assert_macros.svh"

module log_line_severity_counter_unit
  import lls_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  lls_in_if.sink     in_ch,
  lls_out_if.source  out_ch
);

  // ---------------------------------------------------------------- input side
  logic       in_xfer;
  logic [7:0] in_byte;
  logic       is_nl;
  logic       is_zero;
  logic       line_end;
  logic       do_match;

  logic       skid_vld_r;
  logic       in_ready_w;

  assign in_ready_w = !skid_vld_r;
  assign in_ch.ready = in_ready_w;
  assign in_xfer  = in_ch.valid && in_ready_w;
  assign in_byte  = in_ch.data_byte;
  assign is_nl    = (in_byte == BYTE_NL);
  assign is_zero  = (in_byte == BYTE_ZERO);
  assign line_end = is_nl || in_ch.stream_end;

  logic       zero_seen_r;
  logic       zero_seen_nxt;
  logic [3:0] kw_seen_r;
  logic [3:0] kw_seen_nxt;

  assign do_match = !zero_seen_r && !is_zero && !is_nl;

  // ------------------------------------------------------- history cell chain
  logic [HIST_BYTES-1:0][7:0] hist;
  logic                       hist_clear;
  logic                       hist_shift;

  assign hist_clear = in_xfer && line_end;
  assign hist_shift = in_xfer && do_match;

  for (genvar i = 0; i < HIST_BYTES; i++) begin : g_hist
    logic [7:0] d_in;
    if (i == 0) begin : g_head
      assign d_in = in_byte;
    end else begin : g_link
      assign d_in = hist[i-1];
    end
    lls_byte_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (hist_shift),
      .clear    (hist_clear),
      .d        (d_in),
      .q        (hist[i])
    );
  end

  // ------------------------------------------------------------ keyword match
  logic [39:0] win;
  logic [3:0]  hits;
  logic [3:0]  seen_now;
  logic [2:0]  kind;

  assign win = {hist[3], hist[2], hist[1], hist[0], in_byte};

  always_comb begin
    hits    = '0;
    hits[0] = (win == KW_ERROR) || (win == KW_FATAL) || (win[23:0] == KW_ERR);
    hits[1] = (win[31:0] == KW_WARN);
    hits[2] = (win[31:0] == KW_INFO);
    hits[3] = (win == KW_DEBUG);
    if (!do_match) begin
      hits = '0;
    end
  end

  assign seen_now = kw_seen_r | hits;
  assign kind     = line_class(seen_now);

  always_comb begin
    kw_seen_nxt   = kw_seen_r;
    zero_seen_nxt = zero_seen_r;
    if (in_xfer) begin
      if (line_end) begin
        kw_seen_nxt   = '0;
        zero_seen_nxt = 1'b0;
      end else begin
        kw_seen_nxt   = seen_now;
        zero_seen_nxt = zero_seen_r || is_zero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_seen_r   <= '0;
      zero_seen_r <= 1'b0;
    end else begin
      kw_seen_r   <= kw_seen_nxt;
      zero_seen_r <= zero_seen_nxt;
    end
  end

  // ------------------------------------------------------------ counter cells
  logic    res_vld;
  result_t res;
  count_t  cnt [NUM_KIND];

  assign res_vld = in_xfer && line_end;

  for (genvar k = 0; k < NUM_KIND; k++) begin : g_cnt
    lls_count_cell u_cnt (
      .clk       (clk),
      .rst_n     (rst_n),
      .inc       (res_vld && (kind == 3'(k))),
      .count_nxt (cnt[k])
    );
    assign res.totals[k] = OUT_CW'(cnt[k]);
  end

  assign res.line_kind    = kind;
  assign res.final_result = in_ch.stream_end;

  // ------------------------------------------------------ two-slot out buffer
  logic    out_vld_r;
  logic    out_vld_nxt;
  result_t out_data_r;
  result_t out_data_nxt;
  logic    skid_vld_nxt;
  result_t skid_data_r;
  result_t skid_data_nxt;
  logic    out_free;

  assign out_free = !out_vld_r || out_ch.ready;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    if (out_free) begin
      // advance the waiting result first; input is held while it waits
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = res_vld;
        out_data_nxt = res;
      end
    end else if (res_vld) begin
      skid_vld_nxt  = 1'b1;
      skid_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.line_kind    = out_data_r.line_kind;
  assign out_ch.error_total  = out_data_r.totals[KIND_ERROR];
  assign out_ch.warn_total   = out_data_r.totals[KIND_WARN];
  assign out_ch.info_total   = out_data_r.totals[KIND_INFO];
  assign out_ch.debug_total  = out_data_r.totals[KIND_DEBUG];
  assign out_ch.other_total  = out_data_r.totals[KIND_OTHER];
  assign out_ch.final_result = out_data_r.final_result;

  // --------------------------------------------------------------- assertions
  `LLS_ASSERT(a_skid_behind_out, !skid_vld_r || out_vld_r, "skid slot full while output empty")
  `LLS_ASSERT_NEXT(a_line_clears, in_xfer && line_end, (kw_seen_r == 4'd0) && !zero_seen_r, "line state not cleared at line end")
  `LLS_ASSERT_NEXT(a_result_kept, out_vld_r && !out_ch.ready, out_vld_r, "stalled result dropped")
  `LLS_ASSERT(a_kind_valid, !out_vld_r || (out_data_r.line_kind <= KIND_OTHER), "line kind out of range")

endmodule

`default_nettype wire

// ----- dv/log_line_severity_counter_unit_test.sv -----
// Self-checking testbench for the log line severity counter: byte stream in, line tallies out
`timescale 1ns / 100ps

module log_line_severity_counter_unit_test;
  import lls_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] error_n;
    logic [63:0] warn_n;
    logic [63:0] info_n;
    logic [63:0] debug_n;
    logic [63:0] other_n;
    logic        last_line;
  } line_tally_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lls_in_if  in_ch ();
  lls_out_if out_ch ();

  log_line_severity_counter_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Line classifier state mirrored from the block
  logic [31:0] line_hist;
  logic [3:0]  kw_hits;
  logic        zero_hit;
  count_t      class_totals [NUM_KIND];

  line_tally_t pending_tallies [$];
  logic [7:0]  line_buf [$];

  int fail_count    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent    = 0;
  int stall_len     = 0;
  int stall_id      = 0;
  int stall_seen    = 0;
  int stall_left    = 0;

  string kw_words [0:19] = '{"ERROR", "FATAL", "Err", "WARN", "INFO", "DEBUG",
                             "ERRO", "RROR", "Er", "WAR", "ARN", "INF", "NFO",
                             "DEBU", "EBUG", "ERR", "error", "Warn", "FATA", "Info"};

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_count++;
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Advance the line state by one accepted byte; queue a tally at each line end
  function automatic void tally_byte(input logic [7:0] b, input logic last);
    logic [39:0] w;
    logic [2:0]  k;
    line_tally_t t;
    if (!zero_hit) begin
      if (b == BYTE_ZERO) begin
        zero_hit = 1'b1;
      end else if (b != BYTE_NL) begin
        w = {line_hist, b};
        if (w == KW_ERROR || w == KW_FATAL || w[23:0] == KW_ERR) kw_hits[0] = 1'b1;
        if (w[31:0] == KW_WARN) kw_hits[1] = 1'b1;
        if (w[31:0] == KW_INFO) kw_hits[2] = 1'b1;
        if (w == KW_DEBUG) kw_hits[3] = 1'b1;
        line_hist = w[31:0];
      end
    end
    if (b != BYTE_NL && !last) return;

    if (kw_hits[0])      k = KIND_ERROR;
    else if (kw_hits[1]) k = KIND_WARN;
    else if (kw_hits[2]) k = KIND_INFO;
    else if (kw_hits[3]) k = KIND_DEBUG;
    else                 k = KIND_OTHER;
    // saturate rather than wrap
    if (class_totals[k] != {COUNT_WIDTH{1'b1}}) class_totals[k] = class_totals[k] + 1'b1;

    t.kind      = k;
    t.error_n   = 64'(class_totals[KIND_ERROR]);
    t.warn_n    = 64'(class_totals[KIND_WARN]);
    t.info_n    = 64'(class_totals[KIND_INFO]);
    t.debug_n   = 64'(class_totals[KIND_DEBUG]);
    t.other_n   = 64'(class_totals[KIND_OTHER]);
    t.last_line = last;
    pending_tallies.push_back(t);

    line_hist = '0;
    kw_hits   = '0;
    zero_hit  = 1'b0;
  endfunction

  // Offer one byte, idling first at random; valid stays high after the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid      <= 1'b0;
      in_ch.data_byte  <= 8'($urandom);
      in_ch.stream_end <= 1'($urandom);
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.stream_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    tally_byte(b, last);
    bytes_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic send_buf(input bit end_stream);
    for (int i = 0; i < line_buf.size(); i++)
      send_byte(line_buf[i], end_stream && (i == line_buf.size() - 1));
    line_buf.delete();
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Check each result transfer
  always @(posedge clk) begin
    line_tally_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_tallies.size() == 0) begin
        report_mismatch("unexpected result, line_kind", out_ch.line_kind, 0);
      end else begin
        want = pending_tallies.pop_front();
        if (out_ch.line_kind !== want.kind)
          report_mismatch("line_kind", out_ch.line_kind, want.kind);
        if (out_ch.error_total !== want.error_n)
          report_mismatch("error_total", out_ch.error_total, want.error_n);
        if (out_ch.warn_total !== want.warn_n)
          report_mismatch("warn_total", out_ch.warn_total, want.warn_n);
        if (out_ch.info_total !== want.info_n)
          report_mismatch("info_total", out_ch.info_total, want.info_n);
        if (out_ch.debug_total !== want.debug_n)
          report_mismatch("debug_total", out_ch.debug_total, want.debug_n);
        if (out_ch.other_total !== want.other_n)
          report_mismatch("other_total", out_ch.other_total, want.other_n);
        if (out_ch.final_result !== want.last_line)
          report_mismatch("final_result", out_ch.final_result, want.last_line);
      end
    end
  end

  // Drive ready for the next edge; a long hold-off counts down its own cycles
  always @(posedge clk) begin
    if (stall_id != stall_seen) begin
      stall_seen = stall_id;
      stall_left = stall_len;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_special_lines();
    send_idle_pct = 25;
    recv_idle_pct <= 49;
    // a zero byte hides the keyword after it
    push_text("ab");
    line_buf.push_back(BYTE_ZERO);
    push_text("INFO\n");
    push_text("\n");
    // keyword split over two lines matches neither
    push_text("ER\nROR\n");
    send_buf(0);
    line_buf.push_back(8'h0D);
    line_buf.push_back(8'hFF);
    push_text("WARN");
    send_buf(1);
    // newline carrying stream end closes one empty line; counts carry on
    push_text("\n");
    send_buf(1);
    drain_results();
  endtask

  task automatic test_mixed_lines(input int snd_pct, input int rcv_pct, input int n_bytes);
    int start;
    int r;
    send_idle_pct = snd_pct;
    recv_idle_pct <= rcv_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(99) < 85) begin
        repeat ($urandom_range(5)) begin
          r = $urandom_range(99);
          if (r < 35)      push_text(kw_words[$urandom_range(19)]);
          else if (r < 65) repeat ($urandom_range(6, 1)) line_buf.push_back(8'($urandom_range(126, 32)));
          else if (r < 78) line_buf.push_back(8'h20);
          else if (r < 88) line_buf.push_back(8'($urandom_range(255, 1)));
          else if (r < 93) line_buf.push_back(BYTE_ZERO);
          else             line_buf.push_back(8'h0D);
        end
        r = $urandom_range(99);
        if (r < 82) begin
          line_buf.push_back(BYTE_NL);
          send_buf($urandom_range(19) == 0);
        end else if (r < 92) begin
          if (line_buf.size() == 0) line_buf.push_back(8'h2E);
          send_buf(1);
        end else begin
          // leave the line open so the next one joins it
          send_buf(0);
        end
      end else begin
        repeat ($urandom_range(12, 1)) send_byte(8'($urandom), $urandom_range(19) == 0);
      end
    end
    drain_results();
  endtask

  // Hold the result side off long enough to fill the buffer and stall the input
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    stall_len <= 400;
    stall_id  <= stall_id + 1;
    repeat (30) begin
      if ($urandom_range(1)) push_text("\n");
      else push_text("INFO x\n");
      send_buf(0);
    end
    push_text("DEBUG");
    send_buf(1);
    drain_results();
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.stream_end = 1'b0;
    out_ch.ready     = 1'b0;
    line_hist        = '0;
    kw_hits          = '0;
    zero_hit         = 1'b0;
    for (int i = 0; i < NUM_KIND; i++) class_totals[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_special_lines();
    test_mixed_lines(25, 49, 570);
    test_mixed_lines(49, 25, 570);
    test_mixed_lines(0, 0, 570);
    test_output_stall();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lls_pkg.sv
rtl/lls_if.sv
rtl/lls_byte_cell.sv
rtl/lls_count_cell.sv
rtl/log_line_severity_counter_unit.sv
dv/log_line_severity_counter_unit_test.sv
